/* rtl/patterned_filled_ellipse_rasterizer_macros.svh */
// Assertion macros for the patterned filled-ellipse rasterizer checker.
`ifndef PATTERNED_FILLED_ELLIPSE_RASTERIZER_MACROS_SVH
`define PATTERNED_FILLED_ELLIPSE_RASTERIZER_MACROS_SVH

// Same-cycle implication.
`define PFER_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PFER_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/pfer_pkg.sv */
// Shared constants, types and pattern ROM of the filled-ellipse rasterizer.
package pfer_pkg;

   localparam int COORD_BITS    = 16;
   localparam int PATTERN_COUNT = 12;

   localparam int CEN_W   = 15;
   localparam int RAD_W   = 13;
   localparam int COLOR_W = 32;
   localparam int STYLE_W = 4;
   localparam int SQ_W    = 26;
   localparam int COL_W   = 14;
   localparam int ROW_W   = 15;
   localparam int CUR_W   = 16;
   localparam int SLOPE_W = 42;
   localparam int DEC_W   = 58;
   localparam int MOP_W   = 30;
   localparam int PROD_W  = 2 * MOP_W;
   localparam int CALC_W  = 26;
   localparam int CNT_W   = 3;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_RX2,
      MUL_RY2,
      MUL_RX2RY,
      MUL_XX,
      MUL_YMSQ,
      MUL_A,
      MUL_B,
      MUL_C
   } mul_op_type;

   typedef struct packed {
      logic       load;
      logic       step;
      logic       update;
      logic       finalize;
      mul_op_type mul_op;
   } dp_cmd_type;

   typedef struct packed {
      logic is_start;
      logic ends_pair;
      logic out_free;
      logic slope_ge;
      logic upd_r1;
   } dp_status_type;

   localparam logic [7:0] PATTERN_ROM [16][8] = '{
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff},
      '{8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80},
      '{8'h83, 8'h07, 8'h0e, 8'h1c, 8'h38, 8'h70, 8'he0, 8'hc1},
      '{8'hf0, 8'h78, 8'h3c, 8'h1e, 8'h0f, 8'h87, 8'hc3, 8'he1},
      '{8'ha5, 8'hd2, 8'h69, 8'hb4, 8'h5a, 8'h2d, 8'h96, 8'h4b},
      '{8'hff, 8'h88, 8'h88, 8'h88, 8'hff, 8'h88, 8'h88, 8'h88},
      '{8'h81, 8'h42, 8'h24, 8'h18, 8'h18, 8'h24, 8'h42, 8'h81},
      '{8'hcc, 8'h33, 8'hcc, 8'h33, 8'hcc, 8'h33, 8'hcc, 8'h33},
      '{8'h08, 8'h00, 8'h80, 8'h00, 8'h08, 8'h00, 8'h80, 8'h00},
      '{8'h88, 8'h00, 8'h22, 8'h00, 8'h88, 8'h00, 8'h22, 8'h00},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };

   function automatic logic [7:0] pattern_row(input logic [STYLE_W-1:0] style,
                                              input logic [2:0] row);
      logic [7:0] bits;
      bits = 8'h00;
      if (32'(style) < PATTERN_COUNT) begin
         bits = PATTERN_ROM[style][row];
      end
      return bits;
   endfunction

endpackage

/* rtl/pfer_if.sv */
// Request and response channel interfaces of the filled-ellipse rasterizer.
interface pfer_req_if
   import pfer_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic                      command;
   logic signed [CEN_W-1:0]   center_x;
   logic signed [CEN_W-1:0]   center_y;
   logic        [RAD_W-1:0]   radius_x;
   logic        [RAD_W-1:0]   radius_y;
   logic        [COLOR_W-1:0] fill_color;
   logic        [STYLE_W-1:0] fill_style;

   modport source (output valid, command, center_x, center_y, radius_x, radius_y,
                   fill_color, fill_style, input ready);
   modport sink (input valid, command, center_x, center_y, radius_x, radius_y,
                 fill_color, fill_style, output ready);
endinterface

interface pfer_rsp_if
   import pfer_pkg::*;
();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] pixel_x;
   logic signed [COORD_BITS-1:0] pixel_y;
   logic        [COLOR_W-1:0]    pixel_color;
   logic                         last_pixel;

   modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
   modport sink (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

/* rtl/patterned_filled_ellipse_rasterizer.sv */
// Step transaction: its pixel, if any, shows in the cycle after acceptance; one step per cycle
// within a row pair while the output register is free. The last step of a row pair adds the
// update state; entering region 2 adds the seed states (five multiplies through the one shared
// 30x30 multiplier, drain, seed rounding). Start transaction: three multiplies, drain, region
// check, plus seed states if it opens in region 2. Synchronous active-high reset leaves it idle.
module patterned_filled_ellipse_rasterizer
   import pfer_pkg::*;
(
   input logic        clock,
   input logic        reset,
   pfer_req_if.sink   req_if,
   pfer_rsp_if.source rsp_if
);

   dp_cmd_type    cmd;
   dp_status_type status;

   pfer_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pfer_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_command     (req_if.command),
      .req_center_x    (req_if.center_x),
      .req_center_y    (req_if.center_y),
      .req_radius_x    (req_if.radius_x),
      .req_radius_y    (req_if.radius_y),
      .req_fill_color  (req_if.fill_color),
      .req_fill_style  (req_if.fill_style),
      .rsp_ready       (rsp_if.ready),
      .rsp_valid       (rsp_if.valid),
      .rsp_pixel_x     (rsp_if.pixel_x),
      .rsp_pixel_y     (rsp_if.pixel_y),
      .rsp_pixel_color (rsp_if.pixel_color),
      .rsp_last_pixel  (rsp_if.last_pixel)
   );

endmodule

/* rtl/pfer_ctrl.sv */
// Sequencing controller: transaction acceptance, multiply sequences, row-pair update.
module pfer_ctrl
   import pfer_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_READY,
      S_LD,
      S_LD_DRAIN,
      S_LD_CHK,
      S_UPD,
      S_SEED,
      S_SEED_DRAIN,
      S_SEED_FIN
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             accept;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      req_ready = 1'b0;
      accept    = 1'b0;
      cmd       = '0;
      cmd.mul_op = MUL_NONE;
      unique case (state_ff)
         S_READY: begin
            req_ready  = status.out_free;
            accept     = req_valid && status.out_free;
            cmd.load   = accept && status.is_start;
            cmd.step   = accept && !status.is_start;
            if (cmd.load) begin
               state_in = S_LD;
               cnt_in   = '0;
            end else if (cmd.step && status.ends_pair) begin
               state_in = S_UPD;
            end
         end
         S_LD: begin
            unique case (cnt_ff)
               3'd0:    cmd.mul_op = MUL_RX2;
               3'd1:    cmd.mul_op = MUL_RY2;
               default: cmd.mul_op = MUL_RX2RY;
            endcase
            if (cnt_ff == 3'd2) begin
               state_in = S_LD_DRAIN;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         S_LD_DRAIN: state_in = S_LD_CHK;
         S_LD_CHK: begin
            state_in = status.slope_ge ? S_SEED : S_READY;
         end
         S_UPD: begin
            cmd.update = 1'b1;
            cnt_in     = '0;
            state_in   = (status.upd_r1 && status.slope_ge) ? S_SEED : S_READY;
         end
         S_SEED: begin
            unique case (cnt_ff)
               3'd0:    cmd.mul_op = MUL_XX;
               3'd1:    cmd.mul_op = MUL_YMSQ;
               3'd2:    cmd.mul_op = MUL_A;
               3'd3:    cmd.mul_op = MUL_B;
               default: cmd.mul_op = MUL_C;
            endcase
            if (cnt_ff == 3'd4) begin
               state_in = S_SEED_DRAIN;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         S_SEED_DRAIN: state_in = S_SEED_FIN;
         S_SEED_FIN: begin
            cmd.finalize = 1'b1;
            state_in     = S_READY;
         end
         default: state_in = S_READY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_READY;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

/* rtl/pfer_dp.sv */
// Datapath: ellipse state, shared multiplier, span scan, pattern test, output register.
module pfer_dp
   import pfer_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  dp_cmd_type                   cmd,
   output dp_status_type                status,
   input  logic                         req_command,
   input  logic signed [CEN_W-1:0]      req_center_x,
   input  logic signed [CEN_W-1:0]      req_center_y,
   input  logic        [RAD_W-1:0]      req_radius_x,
   input  logic        [RAD_W-1:0]      req_radius_y,
   input  logic        [COLOR_W-1:0]    req_fill_color,
   input  logic        [STYLE_W-1:0]    req_fill_style,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic signed [COORD_BITS-1:0] rsp_pixel_x,
   output logic signed [COORD_BITS-1:0] rsp_pixel_y,
   output logic        [COLOR_W-1:0]    rsp_pixel_color,
   output logic                         rsp_last_pixel
);

   typedef enum logic [1:0] {PH_IDLE, PH_R1, PH_R2} phase_type;

   typedef struct packed {
      phase_type                 phase;
      logic [2:0]                sub;
      logic [CUR_W-1:0]          cur;
      logic signed [CEN_W-1:0]   cx;
      logic signed [CEN_W-1:0]   cy;
      logic [COLOR_W-1:0]        color;
      logic [STYLE_W-1:0]        style;
      logic [RAD_W-1:0]          rx;
      logic [RAD_W-1:0]          ry;
      logic [SQ_W-1:0]           rx2;
      logic [SQ_W-1:0]           ry2;
      logic [COL_W-1:0]          x;
      logic signed [ROW_W-1:0]   y;
      logic signed [SLOPE_W-1:0] sx;
      logic signed [SLOPE_W-1:0] sy;
      logic signed [DEC_W-1:0]   dec;
      logic [2*COL_W-1:0]        xx;
      logic [2*ROW_W-1:0]        ym2;
      logic signed [DEC_W-1:0]   acc;
      mul_op_type                tag;
      logic [PROD_W-1:0]         prod;
      logic                      upd_r1;
      logic                      upd_x;
      logic                      upd_y;
   } dp_state_type;

   typedef struct packed {
      logic                         valid;
      logic signed [COORD_BITS-1:0] px;
      logic signed [COORD_BITS-1:0] py;
      logic [COLOR_W-1:0]           color;
      logic                         last;
   } out_type;

   dp_state_type s_ff, s_in;
   out_type      o_ff, o_in;

   logic [MOP_W-1:0]         mop_a, mop_b;
   logic signed [ROW_W:0]    ym;
   logic [ROW_W:0]           ym_abs;
   logic signed [CALC_W-1:0] col, row;
   logic [7:0]               pat;
   logic                     emit, last, y_le0;
   logic signed [DEC_W+1:0]  seed_sum, seed_q;

   always_comb begin
      ym     = $signed({s_ff.y[ROW_W-1], s_ff.y}) - (ROW_W+1)'(1);
      ym_abs = ym[ROW_W] ? (ROW_W+1)'(-ym) : (ROW_W+1)'(ym);
      mop_a  = '0;
      mop_b  = '0;
      case (cmd.mul_op)
         MUL_RX2:   begin mop_a = MOP_W'(s_ff.rx);   mop_b = MOP_W'(s_ff.rx); end
         MUL_RY2:   begin mop_a = MOP_W'(s_ff.ry);   mop_b = MOP_W'(s_ff.ry); end
         MUL_RX2RY: begin mop_a = MOP_W'(s_ff.rx2);  mop_b = MOP_W'(s_ff.ry); end
         MUL_XX:    begin mop_a = MOP_W'(s_ff.x);    mop_b = MOP_W'(s_ff.x); end
         MUL_YMSQ:  begin mop_a = MOP_W'(ym_abs);    mop_b = MOP_W'(ym_abs); end
         MUL_A: begin
            mop_a = MOP_W'(s_ff.ry2);
            mop_b = MOP_W'(s_ff.xx) + MOP_W'(s_ff.x);
         end
         MUL_B:     begin mop_a = MOP_W'(s_ff.rx2);  mop_b = MOP_W'(s_ff.ym2); end
         MUL_C:     begin mop_a = MOP_W'(s_ff.rx2);  mop_b = MOP_W'(s_ff.ry2); end
         default:   begin mop_a = '0;                mop_b = '0; end
      endcase
   end

   always_comb begin
      s_in      = s_ff;
      o_in      = o_ff;
      emit      = 1'b0;
      last      = 1'b0;
      col       = '0;
      row       = '0;
      pat       = 8'h00;
      y_le0     = s_ff.y[ROW_W-1] || (s_ff.y == '0);
      seed_sum  = $signed({s_ff.acc, 2'b00}) + $signed((DEC_W+2)'(s_ff.ry2));
      seed_q    = (seed_sum >>> 2) +
                  ((seed_sum[DEC_W+1] && (seed_sum[1:0] != 2'b00)) ?
                   (DEC_W+2)'(1) : (DEC_W+2)'(0));

      if (rsp_ready) begin
         o_in.valid = 1'b0;
      end

      s_in.tag  = cmd.mul_op;
      s_in.prod = PROD_W'(mop_a) * PROD_W'(mop_b);
      case (s_ff.tag)
         MUL_RX2:   s_in.rx2 = s_ff.prod[SQ_W-1:0];
         MUL_RY2:   s_in.ry2 = s_ff.prod[SQ_W-1:0];
         MUL_RX2RY: begin
            s_in.sy  = SLOPE_W'({s_ff.prod, 1'b0});
            s_in.dec = DEC_W'(s_ff.ry2) - DEC_W'(s_ff.prod) + DEC_W'(s_ff.rx2[SQ_W-1:2]);
         end
         MUL_XX:    s_in.xx  = s_ff.prod[2*COL_W-1:0];
         MUL_YMSQ:  s_in.ym2 = s_ff.prod[2*ROW_W-1:0];
         MUL_A:     s_in.acc = DEC_W'(s_ff.prod);
         MUL_B:     s_in.acc = s_ff.acc + DEC_W'(s_ff.prod);
         MUL_C:     s_in.acc = s_ff.acc - DEC_W'(s_ff.prod);
         default:   s_in.acc = s_ff.acc;
      endcase

      if (cmd.load) begin
         s_in.cx    = req_center_x;
         s_in.cy    = req_center_y;
         s_in.color = req_fill_color;
         s_in.style = req_fill_style;
         s_in.rx    = req_radius_x;
         s_in.ry    = req_radius_y;
         s_in.x     = '0;
         s_in.y     = ROW_W'(req_radius_y);
         s_in.sx    = '0;
         s_in.sub   = '0;
         s_in.cur   = '0;
         s_in.phase = PH_R1;
      end

      if (cmd.step && (s_ff.phase != PH_IDLE)) begin
         case (s_ff.sub)
            3'd0, 3'd1: begin
               row = (s_ff.sub == 3'd0) ? CALC_W'(s_ff.cy) + CALC_W'(s_ff.y)
                                        : CALC_W'(s_ff.cy) - CALC_W'(s_ff.y);
               col = CALC_W'(s_ff.cx) - CALC_W'(s_ff.x) + CALC_W'(s_ff.cur);
               pat  = pattern_row(s_ff.style, row[2:0]);
               emit = pat[~col[2:0]];
               if (s_ff.cur >= CUR_W'({s_ff.x, 1'b0})) begin
                  s_in.cur = '0;
                  s_in.sub = s_ff.sub + 3'd1;
               end else begin
                  s_in.cur = s_ff.cur + CUR_W'(1);
               end
            end
            3'd2, 3'd3, 3'd4, 3'd5: begin
               col = !s_ff.sub[0] ? CALC_W'(s_ff.cx) + CALC_W'(s_ff.x)
                                  : CALC_W'(s_ff.cx) - CALC_W'(s_ff.x);
               row = (s_ff.sub < 3'd4) ? CALC_W'(s_ff.cy) + CALC_W'(s_ff.y)
                                       : CALC_W'(s_ff.cy) - CALC_W'(s_ff.y);
               emit = 1'b1;
               if (s_ff.sub == 3'd5) begin
                  last     = (s_ff.phase == PH_R2) && y_le0;
                  s_in.sub = '0;
                  if (s_ff.phase == PH_R1) begin
                     s_in.upd_r1 = 1'b1;
                     s_in.x      = s_ff.x + COL_W'(1);
                     s_in.sx     = s_ff.sx + SLOPE_W'({s_ff.ry2, 1'b0});
                     s_in.upd_y  = !s_ff.dec[DEC_W-1];
                     if (!s_ff.dec[DEC_W-1]) begin
                        s_in.y  = s_ff.y - ROW_W'(1);
                        s_in.sy = s_ff.sy - SLOPE_W'({s_ff.rx2, 1'b0});
                     end
                  end else if (y_le0) begin
                     s_in.upd_r1 = 1'b0;
                     s_in.phase  = PH_IDLE;
                  end else begin
                     s_in.upd_r1 = 1'b0;
                     s_in.y      = s_ff.y - ROW_W'(1);
                     s_in.sy     = s_ff.sy - SLOPE_W'({s_ff.rx2, 1'b0});
                     s_in.upd_x  = s_ff.dec[DEC_W-1] || (s_ff.dec == '0);
                     if (s_ff.dec[DEC_W-1] || (s_ff.dec == '0)) begin
                        s_in.x  = s_ff.x + COL_W'(1);
                        s_in.sx = s_ff.sx + SLOPE_W'({s_ff.ry2, 1'b0});
                     end
                  end
               end else begin
                  s_in.sub = s_ff.sub + 3'd1;
               end
            end
            default: s_in.sub = '0;
         endcase
         if (emit) begin
            o_in.valid = 1'b1;
            o_in.px    = col[COORD_BITS-1:0];
            o_in.py    = row[COORD_BITS-1:0];
            o_in.color = s_ff.color;
            o_in.last  = last;
         end
      end

      if (cmd.update) begin
         if (s_ff.upd_r1) begin
            s_in.dec = s_ff.dec + DEC_W'(s_ff.ry2) + DEC_W'(s_ff.sx)
                       - (s_ff.upd_y ? DEC_W'(s_ff.sy) : DEC_W'(0));
         end else begin
            s_in.dec = s_ff.dec + DEC_W'(s_ff.rx2) - DEC_W'(s_ff.sy)
                       + (s_ff.upd_x ? DEC_W'(s_ff.sx) : DEC_W'(0));
         end
      end

      if (cmd.finalize) begin
         s_in.dec   = seed_q[DEC_W-1:0];
         s_in.phase = PH_R2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_ff <= '0;
         o_ff <= '0;
      end else begin
         s_ff <= s_in;
         o_ff <= o_in;
      end
   end

   assign status.is_start  = (req_command == CMD_START);
   assign status.ends_pair = (s_ff.phase != PH_IDLE) && (s_ff.sub == 3'd5);
   assign status.out_free  = !o_ff.valid || rsp_ready;
   assign status.slope_ge  = !(s_ff.sx < s_ff.sy);
   assign status.upd_r1    = s_ff.upd_r1;

   assign rsp_valid       = o_ff.valid;
   assign rsp_pixel_x     = o_ff.px;
   assign rsp_pixel_y     = o_ff.py;
   assign rsp_pixel_color = o_ff.color;
   assign rsp_last_pixel  = o_ff.last;

endmodule

/* rtl/pfer_checker.sv */
// Port-level checker of the filled-ellipse rasterizer and its bind.
`include "patterned_filled_ellipse_rasterizer_macros.svh"

module pfer_checker
   import pfer_pkg::*;
(
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_command,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [COORD_BITS-1:0] rsp_pixel_x,
   input logic signed [COORD_BITS-1:0] rsp_pixel_y,
   input logic        [COLOR_W-1:0]    rsp_pixel_color,
   input logic                         rsp_last_pixel
);

   `PFER_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_pixel_x, rsp_pixel_y, rsp_pixel_color, rsp_last_pixel}), "stalled response transaction changed")
   `PFER_ASSERT_IMP(a_ready_room, clock, reset, req_ready, !rsp_valid || rsp_ready, "request taken with no room for its result")
   `PFER_ASSERT_NXT(a_start_busy, clock, reset, req_valid && req_ready && (req_command == CMD_START), !req_ready, "start transaction not followed by setup")

endmodule

bind patterned_filled_ellipse_rasterizer pfer_checker u_pfer_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .req_command     (req_if.command),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_pixel_x     (rsp_if.pixel_x),
   .rsp_pixel_y     (rsp_if.pixel_y),
   .rsp_pixel_color (rsp_if.pixel_color),
   .rsp_last_pixel  (rsp_if.last_pixel)
);

/* bench/tb.sv */
// Self-checking testbench for the patterned filled-ellipse rasterizer.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pfer_pkg::*;

   typedef enum int {DRAW_IDLE, DRAW_OUTER, DRAW_INNER} draw_phase_type;

   typedef struct {
      logic                cmd;
      logic signed [14:0]  cx;
      logic signed [14:0]  cy;
      logic [12:0]         rx;
      logic [12:0]         ry;
      logic [31:0]         color;
      logic [3:0]          style;
      int                  gap;
      bit                  drain;
   } cmd_item_type;

   typedef struct {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic [31:0]                  color;
      logic                         last;
   } pixel_type;

   typedef struct {
      draw_phase_type ph;
      int             sub;
      longint         cur, cx, cy;
      logic [31:0]    color;
      int             style;
      longint         rx2, ry2, x, y, px, py, d;
   } ellipse_state_type;

   localparam int CYCLE_LIMIT = 400000;

   logic clock;
   logic reset;
   pfer_req_if req_if ();
   pfer_rsp_if rsp_if ();

   patterned_filled_ellipse_rasterizer dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   cmd_item_type      pending_cmds[$];
   pixel_type         expected_pixels[$];
   ellipse_state_type gen_state, live_state;
   int             errors, cycles, gap_left, hold_left, n_starts, n_steps, n_pixels, n_lasts;
   bit             took, generating, long_hold_done;

   task automatic report(input string what, input longint got, input longint want);
      errors++;
      $display("MISMATCH %s: got %0d expected %0d (pixel %0d)", what, got, want, n_pixels);
   endtask

   function automatic void seed_inner(ref ellipse_state_type s);
      longint t;
      t = s.ry2 * (s.x * s.x + s.x) + s.rx2 * (s.y - 1) * (s.y - 1) - s.rx2 * s.ry2;
      s.d = (4 * t + s.ry2) / 4;
      s.ph = DRAW_INNER;
   endfunction

   function automatic void advance_pair(ref ellipse_state_type s);
      if (s.ph == DRAW_OUTER) begin
         s.x++;
         s.px += 2 * s.ry2;
         if (s.d < 0) begin
            s.d += s.ry2 + s.px;
         end else begin
            s.y--;
            s.py -= 2 * s.rx2;
            s.d += s.ry2 + s.px - s.py;
         end
         if (!(s.px < s.py)) seed_inner(s);
      end else if (s.y <= 0) begin
         s.ph = DRAW_IDLE;
      end else begin
         s.y--;
         s.py -= 2 * s.rx2;
         if (s.d > 0) begin
            s.d += s.rx2 - s.py;
         end else begin
            s.x++;
            s.px += 2 * s.ry2;
            s.d += s.rx2 - s.py + s.px;
         end
      end
   endfunction

   function automatic bit raster_step(ref ellipse_state_type s, input cmd_item_type it,
                                      output pixel_type p);
      longint col, row, rx, ry;
      bit     emit;
      logic [7:0] bits;
      emit = 0;
      p.last = 0;
      if (it.cmd == CMD_START) begin
         rx = longint'(it.rx);
         ry = longint'(it.ry);
         s.cx = longint'(it.cx);
         s.cy = longint'(it.cy);
         s.color = it.color;
         s.style = int'(it.style);
         s.rx2 = rx * rx;
         s.ry2 = ry * ry;
         s.x = 0;
         s.y = ry;
         s.px = 0;
         s.py = 2 * s.rx2 * ry;
         s.d = s.ry2 - s.rx2 * ry + s.rx2 / 4;
         s.sub = 0;
         s.cur = 0;
         s.ph = DRAW_OUTER;
         if (!(s.px < s.py)) seed_inner(s);
         return 0;
      end
      if (s.ph == DRAW_IDLE) return 0;
      if (s.sub < 2) begin
         row = (s.sub == 0) ? s.cy + s.y : s.cy - s.y;
         col = s.cx - s.x + s.cur;
         bits = (s.style < PATTERN_COUNT) ? PATTERN_ROM[s.style][row & 7] : 8'h00;
         emit = bits[7 - (col & 7)];
         if (s.cur >= 2 * s.x) begin
            s.cur = 0;
            s.sub++;
         end else begin
            s.cur++;
         end
      end else begin
         col = (s.sub % 2 == 0) ? s.cx + s.x : s.cx - s.x;
         row = (s.sub < 4) ? s.cy + s.y : s.cy - s.y;
         emit = 1;
         if (s.sub == 5) begin
            p.last = (s.ph == DRAW_INNER && s.y <= 0);
            s.sub = 0;
            advance_pair(s);
         end else begin
            s.sub++;
         end
      end
      p.x = col[COORD_BITS-1:0];
      p.y = row[COORD_BITS-1:0];
      p.color = s.color;
      return emit;
   endfunction

   function automatic int pick_gap(input bit busy_stretch);
      int r;
      r = $urandom_range(99);
      if (busy_stretch || r < 60) return 0;
      if (r < 93) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   bit busy_stretch;

   task automatic queue_cmd(input cmd_item_type it);
      pixel_type p;
      if ($urandom_range(49) == 0) busy_stretch = !busy_stretch;
      it.gap = pick_gap(busy_stretch);
      void'(raster_step(gen_state, it, p));
      pending_cmds.push_back(it);
   endtask

   task automatic queue_start(input int cx, input int cy, input int rx, input int ry,
                              input logic [31:0] color, input int style, input bit drain);
      cmd_item_type it;
      it.cmd = CMD_START;
      it.cx = cx[14:0];
      it.cy = cy[14:0];
      it.rx = rx[12:0];
      it.ry = ry[12:0];
      it.color = color;
      it.style = style[3:0];
      it.drain = drain;
      queue_cmd(it);
   endtask

   task automatic queue_steps(input int count);
      cmd_item_type it;
      it.cmd = CMD_STEP;
      it.drain = 0;
      for (int i = 0; i < count; i++) begin
         it.cx = 15'($urandom);
         it.cy = 15'($urandom);
         it.rx = 13'($urandom);
         it.ry = 13'($urandom);
         it.color = $urandom;
         it.style = 4'($urandom);
         queue_cmd(it);
      end
   endtask

   task automatic queue_full_ellipse();
      while (gen_state.ph != DRAW_IDLE) queue_steps(1);
   endtask

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      int rx, ry;
      reset = 1;
      req_if.valid = 0;
      req_if.command = CMD_STEP;
      req_if.center_x = 0;
      req_if.center_y = 0;
      req_if.radius_x = 0;
      req_if.radius_y = 0;
      req_if.fill_color = 0;
      req_if.fill_style = 0;
      rsp_if.ready = 0;
      gen_state = '{ph: DRAW_IDLE, color: 0, default: 0};
      live_state = gen_state;
      generating = 1;

      // directed
      queue_steps(2);
      queue_start(0, 0, 0, 0, 32'hffffffff, 1, 0);
      queue_full_ellipse();
      queue_steps(1);
      queue_start(-16384, 16383, 8191, 8191, 32'h0, 15, 0);
      queue_steps(12);
      queue_start(16383, -16384, 8191, 0, 32'ha5a5a5a5, 9, 0);
      queue_steps(6);
      queue_start(16383, 16383, 0, 8191, 32'h5a5a5a5a, 6, 0);
      queue_steps(6);
      queue_start(-16384, -16384, 3, 2, 32'h12345678, 12, 1);
      queue_full_ellipse();
      for (int st = 0; st < 16; st++) begin
         queue_start($urandom_range(32767) - 16384, $urandom_range(32767) - 16384,
                     $urandom_range(1), $urandom_range(1), $urandom, st, 0);
         queue_full_ellipse();
      end

      // random
      while (pending_cmds.size() < 480) begin
         rx = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(5);
         ry = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(5);
         if ($urandom_range(14) == 0) begin
            rx = $urandom_range(8191);
            ry = $urandom_range(8191);
         end
         queue_start($urandom_range(32767) - 16384, $urandom_range(32767) - 16384, rx, ry,
                     $urandom, $urandom_range(15), $urandom_range(29) == 0);
         if (rx > 5 || ry > 5 || $urandom_range(9) == 0) begin
            queue_steps($urandom_range(40, 1));
         end else begin
            queue_full_ellipse();
            queue_steps($urandom_range(2));
         end
      end
      generating = 0;

      repeat (3) @(posedge clock);
      reset <= 0;
      wait (pending_cmds.size() == 0 && !req_if.valid);
      wait (expected_pixels.size() == 0);
      repeat (40) @(posedge clock);
      $display("Covered %0d starts and %0d steps, %0d pixels checked, %0d ellipses finished.",
               n_starts, n_steps, n_pixels, n_lasts);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 0;
         gap_left <= 0;
      end else if (!req_if.valid || took) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_if.valid <= 0;
         end else if (pending_cmds.size() > 0 &&
                      !(pending_cmds[0].drain && expected_pixels.size() > 0)) begin
            cmd_item_type it;
            it = pending_cmds.pop_front();
            req_if.command <= it.cmd;
            req_if.center_x <= it.cx;
            req_if.center_y <= it.cy;
            req_if.radius_x <= it.rx;
            req_if.radius_y <= it.ry;
            req_if.fill_color <= it.color;
            req_if.fill_style <= it.style;
            req_if.valid <= 1;
            gap_left <= it.gap;
         end else begin
            req_if.valid <= 0;
         end
      end
   end

   // receiver backpressure, with one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_if.ready <= 0;
      end else if (!long_hold_done && n_pixels > 150) begin
         long_hold_done <= 1;
         hold_left <= 300;
         rsp_if.ready <= 0;
      end else begin
         int r;
         r = $urandom_range(99);
         if (busy_stretch || r < 70) begin
            rsp_if.ready <= 1;
         end else if (r < 96) begin
            rsp_if.ready <= 0;
            hold_left <= $urandom_range(3);
         end else begin
            rsp_if.ready <= 0;
            hold_left <= $urandom_range(30, 8);
         end
      end
   end

   // transaction capture and prediction
   always @(posedge clock) begin
      took <= 0;
      if (!reset && req_if.valid && req_if.ready) begin
         cmd_item_type it;
         pixel_type    p;
         took <= 1;
         it.cmd = req_if.command;
         it.cx = req_if.center_x;
         it.cy = req_if.center_y;
         it.rx = req_if.radius_x;
         it.ry = req_if.radius_y;
         it.color = req_if.fill_color;
         it.style = req_if.fill_style;
         if (it.cmd == CMD_START) n_starts++;
         else n_steps++;
         if (raster_step(live_state, it, p)) expected_pixels.push_back(p);
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         pixel_type want;
         if (expected_pixels.size() == 0) begin
            report("unexpected pixel x", rsp_if.pixel_x, 0);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_if.pixel_x !== want.x) report("pixel_x", rsp_if.pixel_x, want.x);
            if (rsp_if.pixel_y !== want.y) report("pixel_y", rsp_if.pixel_y, want.y);
            if (rsp_if.pixel_color !== want.color)
               report("pixel_color", rsp_if.pixel_color, want.color);
            if (rsp_if.last_pixel !== want.last)
               report("last_pixel", rsp_if.last_pixel, want.last);
            if (want.last) n_lasts++;
         end
         n_pixels++;
      end
   end

endmodule

/* files.f */
+incdir+rtl
rtl/pfer_pkg.sv
rtl/pfer_if.sv
rtl/pfer_ctrl.sv
rtl/pfer_dp.sv
rtl/patterned_filled_ellipse_rasterizer.sv
rtl/pfer_checker.sv
bench/tb.sv
